[design/rmi_pkg.sv]
// ----------------------------------------------------------------------------
// rmi_pkg: shared types and constants for the regularized matrix inverse unit
// Sizes, Q40.24 limits, datapath select codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package rmi_pkg;

    localparam int N  = 8;
    localparam int IW = $clog2(N);
    localparam int AW = $clog2(N * N);
    localparam int DW = 32;
    localparam int QW = 64;
    localparam int EW = 31;

    localparam logic [QW-1:0]        LIM_U     = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [QW-1:0] LIM       = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [QW-1:0] ONE_Q     = 64'sh0000_0000_0100_0000;
    localparam logic [EW-1:0]        ETA_RESET = 31'd16777;

    localparam logic       SRC_A_IN   = 1'b0;
    localparam logic       SRC_A_FACT = 1'b1;

    localparam logic [1:0] SRC_B_IN   = 2'd0;
    localparam logic [1:0] SRC_B_FACT = 2'd1;
    localparam logic [1:0] SRC_B_FWD  = 2'd2;
    localparam logic [1:0] SRC_B_BWD  = 2'd3;

    localparam logic [2:0] INIT_ZERO  = 3'd0;
    localparam logic [2:0] INIT_ETA   = 3'd1;
    localparam logic [2:0] INIT_ONE   = 3'd2;
    localparam logic [2:0] INIT_GRAM  = 3'd3;
    localparam logic [2:0] INIT_FWD   = 3'd4;

    localparam logic [1:0] DST_GRAM   = 2'd0;
    localparam logic [1:0] DST_FACT   = 2'd1;
    localparam logic [1:0] DST_FWD    = 2'd2;
    localparam logic [1:0] DST_BWD    = 2'd3;

    localparam logic [1:0] OP_MUL     = 2'd0;
    localparam logic [1:0] OP_DIV     = 2'd1;
    localparam logic [1:0] OP_SQRT    = 2'd2;

    typedef struct packed {
        logic          in_we;
        logic [AW-1:0] in_addr;
        logic [AW-1:0] addr_a;
        logic [AW-1:0] addr_b;
        logic          src_a;
        logic [1:0]    src_b;
        logic          init_load;
        logic [2:0]    init_sel;
        logic          acc_update;
        logic          acc_sub;
        logic          arith_start;
        logic [1:0]    arith_op;
        logic          wr_en;
        logic [1:0]    wr_dst;
        logic [AW-1:0] wr_addr;
        logic          out_load;
        logic          out_err;
        logic [IW-1:0] out_row;
        logic [IW-1:0] out_col;
        logic          out_last;
    } rmi_cmd_t;

    typedef struct packed {
        logic arith_done;
        logic acc_nonpos;
        logic out_free;
    } rmi_sts_t;

    function automatic logic [AW-1:0] idx(input logic [IW-1:0] r, input logic [IW-1:0] c);
        idx = AW'(int'(r) * N + int'(c));
    endfunction

endpackage

[design/rmi_arith.sv]
// ----------------------------------------------------------------------------
// rmi_arith: shared multi-cycle arithmetic unit
// Q.24 multiply (four 32x32 partial products), restoring divide, square root.
// ----------------------------------------------------------------------------
module rmi_arith
    import rmi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           op,
    input  logic signed [QW-1:0] a,
    input  logic signed [QW-1:0] b,
    output logic                 done,
    output logic signed [QW-1:0] res
);

    localparam logic [6:0] MUL_LAST  = 7'd5;
    localparam logic [6:0] DIV_LAST  = 7'd87;
    localparam logic [6:0] SQRT_LAST = 7'd63;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [6:0]           cnt_reg, cnt_next;
    logic [1:0]           op_reg, op_next;
    logic                 neg_reg, neg_next;
    logic [QW-1:0]        ua_reg, ua_next;
    logic [QW-1:0]        ub_reg, ub_next;
    logic [127:0]         acc_reg, acc_next;
    logic [QW-1:0]        pp_reg, pp_next;
    logic [1:0]           sh_reg, sh_next;
    logic [65:0]          rem_reg, rem_next;
    logic [QW-1:0]        q_reg, q_next;
    logic                 sat_reg, sat_next;
    logic [127:0]         v_reg, v_next;
    logic signed [QW-1:0] res_reg, res_next;

    logic [QW-1:0]  a_mag, b_mag;
    logic [31:0]    a_part, b_part;
    logic [127:0]   pp_ext, acc_add, p2;
    logic [QW-1:0]  mul_r;
    logic [QW-1:0]  div_rsh, div_q, div_qf;
    logic           div_ge;
    logic [65:0]    sq_rsh, sq_trial;
    logic           sq_ge;

    assign a_mag    = a[QW-1] ? QW'(-a) : QW'(a);
    assign b_mag    = b[QW-1] ? QW'(-b) : QW'(b);
    assign a_part   = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
    assign b_part   = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];

    always_comb
    begin
        case (sh_reg)
            2'd0:    pp_ext = {64'b0, pp_reg};
            2'd1:    pp_ext = {32'b0, pp_reg, 32'b0};
            default: pp_ext = {pp_reg, 64'b0};
        endcase
    end

    assign acc_add  = acc_reg + pp_ext;
    assign p2       = acc_reg + 128'h80_0000;
    assign mul_r    = ((|p2[127:86]) || (|p2[87:86])) ? LIM_U : p2[87:24];

    assign div_rsh  = {rem_reg[62:0], v_reg[127]};
    assign div_ge   = div_rsh >= ub_reg;
    assign div_q    = {q_reg[62:0], div_ge};
    assign div_qf   = (sat_reg || (div_q > LIM_U)) ? LIM_U : div_q;

    assign sq_rsh   = {rem_reg[63:0], v_reg[127:126]};
    assign sq_trial = {q_reg, 2'b01};
    assign sq_ge    = sq_rsh >= sq_trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        neg_next  = neg_reg;
        ua_next   = ua_reg;
        ub_next   = ub_reg;
        acc_next  = acc_reg;
        pp_next   = pp_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        if (start)
        begin
            op_next  = op;
            cnt_next = '0;
            rem_next = '0;
            q_next   = '0;
            sat_next = 1'b0;
            acc_next = '0;
            case (op)
                OP_MUL:
                begin
                    busy_next = 1'b1;
                    ua_next   = a_mag;
                    ub_next   = b_mag;
                    neg_next  = a[QW-1] != b[QW-1];
                end
                OP_DIV:
                begin
                    neg_next = a[QW-1];
                    ub_next  = QW'(b);
                    v_next   = {a_mag, 64'b0};
                    if (b <= 0)
                    begin
                        res_next  = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        busy_next = 1'b1;
                    end
                end
                default:
                begin
                    busy_next = 1'b1;
                    v_next    = {40'b0, a, 24'b0};
                end
            endcase
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 7'd1;
            case (op_reg)
                OP_MUL:
                begin
                    pp_next = a_part * b_part;
                    sh_next = 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
                    if (cnt_reg != 7'd0 && cnt_reg != MUL_LAST)
                    begin
                        acc_next = acc_add;
                    end
                    if (cnt_reg == MUL_LAST)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        res_next  = neg_reg ? -$signed(mul_r) : $signed(mul_r);
                    end
                end
                OP_DIV:
                begin
                    v_next   = {v_reg[126:0], 1'b0};
                    rem_next = {2'b0, div_ge ? div_rsh - ub_reg : div_rsh};
                    q_next   = div_q;
                    sat_next = sat_reg || (div_q > LIM_U);
                    if (cnt_reg == DIV_LAST)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        res_next  = neg_reg ? -$signed(div_qf) : $signed(div_qf);
                    end
                end
                default:
                begin
                    v_next   = {v_reg[125:0], 2'b0};
                    rem_next = sq_ge ? sq_rsh - sq_trial : sq_rsh;
                    q_next   = {q_reg[62:0], sq_ge};
                    if (cnt_reg == SQRT_LAST)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        res_next  = $signed({q_reg[62:0], sq_ge});
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        ua_reg  <= ua_next;
        ub_reg  <= ub_next;
        acc_reg <= acc_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
        v_reg   <= v_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

[design/rmi_dp.sv]
// ----------------------------------------------------------------------------
// rmi_dp: datapath of the regularized matrix inverse unit
// Element stores, accumulator, shared arithmetic unit and output register.
// ----------------------------------------------------------------------------
module rmi_dp
    import rmi_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  rmi_cmd_t       cmd,
    output rmi_sts_t       sts,
    input  logic [DW-1:0]  s_tdata,
    input  logic           cfg_we,
    input  logic [EW-1:0]  cfg_data,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [39:0]    m_tdata,
    output logic           m_tlast,
    output logic [1:0]     m_tuser
);

    logic [DW-1:0]        in_mem   [N*N];
    logic signed [QW-1:0] gram_mem [N*N];
    logic signed [QW-1:0] fact_mem [N*N];
    logic signed [QW-1:0] fwd_mem  [N];
    logic signed [QW-1:0] bwd_mem  [N];

    logic [DW-1:0]        in_rd_a, in_rd_b;
    logic signed [QW-1:0] gram_rd, fact_rd_a, fact_rd_b, fwd_rd, bwd_rd;

    logic [EW-1:0]        eta_reg;
    logic signed [QW-1:0] acc_reg, acc_next;
    logic signed [QW-1:0] op_a, op_b, ar_a, ar_b, ar_res, init_val;
    logic signed [QW:0]   sum;
    logic                 ar_done;

    logic                 valid_reg;
    logic [DW-1:0]        val_reg;
    logic [IW-1:0]        row_reg, col_reg;
    logic                 last_reg, npd_reg, sat_reg;
    logic                 out_hi, out_lo;

    always_ff @(posedge clk)
    begin
        if (cmd.in_we)
        begin
            in_mem[cmd.in_addr] <= s_tdata;
        end
        in_rd_a <= in_mem[cmd.addr_a];
        in_rd_b <= in_mem[cmd.addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && cmd.wr_dst == DST_GRAM)
        begin
            gram_mem[cmd.wr_addr] <= acc_reg;
        end
        gram_rd <= gram_mem[cmd.addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && cmd.wr_dst == DST_FACT)
        begin
            fact_mem[cmd.wr_addr] <= ar_res;
        end
        fact_rd_a <= fact_mem[cmd.addr_a];
        fact_rd_b <= fact_mem[cmd.addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && cmd.wr_dst == DST_FWD)
        begin
            fwd_mem[cmd.wr_addr[IW-1:0]] <= ar_res;
        end
        fwd_rd <= fwd_mem[cmd.addr_b[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && cmd.wr_dst == DST_BWD)
        begin
            bwd_mem[cmd.wr_addr[IW-1:0]] <= ar_res;
        end
        bwd_rd <= bwd_mem[cmd.addr_b[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_reg <= ETA_RESET;
        end
        else if (cfg_we)
        begin
            eta_reg <= cfg_data;
        end
    end

    assign op_a = (cmd.src_a == SRC_A_IN) ? QW'(signed'(in_rd_a)) : fact_rd_a;

    always_comb
    begin
        case (cmd.src_b)
            SRC_B_IN:   op_b = QW'(signed'(in_rd_b));
            SRC_B_FACT: op_b = fact_rd_b;
            SRC_B_FWD:  op_b = fwd_rd;
            default:    op_b = bwd_rd;
        endcase
    end

    always_comb
    begin
        case (cmd.arith_op)
            OP_MUL:
            begin
                ar_a = op_a;
                ar_b = op_b;
            end
            OP_DIV:
            begin
                ar_a = acc_reg;
                ar_b = fact_rd_a;
            end
            default:
            begin
                ar_a = acc_reg;
                ar_b = '0;
            end
        endcase
    end

    rmi_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.arith_start),
        .op    (cmd.arith_op),
        .a     (ar_a),
        .b     (ar_b),
        .done  (ar_done),
        .res   (ar_res)
    );

    always_comb
    begin
        case (cmd.init_sel)
            INIT_ETA:  init_val = $signed({33'b0, eta_reg});
            INIT_ONE:  init_val = ONE_Q;
            INIT_GRAM: init_val = gram_rd;
            INIT_FWD:  init_val = fwd_rd;
            default:   init_val = '0;
        endcase
    end

    assign sum = cmd.acc_sub ? (QW+1)'(acc_reg) - (QW+1)'(ar_res)
                             : (QW+1)'(acc_reg) + (QW+1)'(ar_res);

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.init_load)
        begin
            acc_next = init_val;
        end
        else if (cmd.acc_update)
        begin
            if (sum > (QW+1)'(LIM))
            begin
                acc_next = LIM;
            end
            else if (sum < -(QW+1)'(LIM))
            begin
                acc_next = -LIM;
            end
            else
            begin
                acc_next = sum[QW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign out_hi = bwd_rd > 64'sh0000_0000_7FFF_FFFF;
    assign out_lo = bwd_rd < -64'sh0000_0000_8000_0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.out_load || cmd.out_err)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            val_reg  <= out_hi ? 32'h7FFF_FFFF : (out_lo ? 32'h8000_0000 : bwd_rd[DW-1:0]);
            row_reg  <= cmd.out_row;
            col_reg  <= cmd.out_col;
            last_reg <= cmd.out_last;
            npd_reg  <= 1'b0;
            sat_reg  <= out_hi || out_lo;
        end
        else if (cmd.out_err)
        begin
            val_reg  <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            last_reg <= 1'b1;
            npd_reg  <= 1'b1;
            sat_reg  <= 1'b0;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b0, col_reg, row_reg, val_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = {sat_reg, npd_reg};

    assign sts.arith_done = ar_done;
    assign sts.acc_nonpos = acc_reg <= 0;
    assign sts.out_free   = !valid_reg || m_tready;

endmodule

[design/rmi_ctrl.sv]
// ----------------------------------------------------------------------------
// rmi_ctrl: controller of the regularized matrix inverse unit
// Walks load, Gram product, Cholesky, substitution and output sequences.
// ----------------------------------------------------------------------------
module rmi_ctrl
    import rmi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output rmi_cmd_t cmd,
    input  rmi_sts_t sts
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INIT_RD  = 4'd1;
    localparam logic [3:0] S_INIT_LD  = 4'd2;
    localparam logic [3:0] S_OP_RD    = 4'd3;
    localparam logic [3:0] S_MUL      = 4'd4;
    localparam logic [3:0] S_MUL_WAIT = 4'd5;
    localparam logic [3:0] S_FIN_RD   = 4'd6;
    localparam logic [3:0] S_FIN      = 4'd7;
    localparam logic [3:0] S_FIN_WAIT = 4'd8;
    localparam logic [3:0] S_WR       = 4'd9;
    localparam logic [3:0] S_OUT_RD   = 4'd10;
    localparam logic [3:0] S_OUT_LD   = 4'd11;
    localparam logic [3:0] S_ERR      = 4'd12;

    localparam logic [1:0] PH_GRAM = 2'd0;
    localparam logic [1:0] PH_FACT = 2'd1;
    localparam logic [1:0] PH_FWD  = 2'd2;
    localparam logic [1:0] PH_BWD  = 2'd3;

    localparam logic [IW-1:0] IMAX = IW'(N - 1);

    logic [3:0]    state_reg, state_next;
    logic [1:0]    phase_reg, phase_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] col_reg, col_next;
    logic [AW-1:0] load_reg, load_next;

    logic [IW:0]   nterms;
    logic [IW-1:0] p_bw;
    logic          last_term;

    always_comb
    begin
        case (phase_reg)
            PH_GRAM: nterms = (IW+1)'(N);
            PH_BWD:  nterms = (IW+1)'(IMAX - i_reg);
            default: nterms = (IW+1)'(i_reg);
        endcase
    end

    assign p_bw      = IMAX - k_reg;
    assign last_term = ((IW+1)'(k_reg) + (IW+1)'(1)) == nterms;
    assign s_tready  = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        col_next   = col_reg;
        load_next  = load_reg;
        cmd        = '0;
        cmd.in_addr = load_reg;
        cmd.out_row = col_reg;
        cmd.out_col = i_reg;
        cmd.out_last = (col_reg == IMAX) && (i_reg == IMAX);
        cmd.acc_sub = phase_reg != PH_GRAM;
        case (phase_reg)
            PH_GRAM:
            begin
                cmd.src_a  = SRC_A_IN;
                cmd.src_b  = SRC_B_IN;
                cmd.wr_dst = DST_GRAM;
            end
            PH_FACT:
            begin
                cmd.src_a  = SRC_A_FACT;
                cmd.src_b  = SRC_B_FACT;
                cmd.wr_dst = DST_FACT;
            end
            PH_FWD:
            begin
                cmd.src_a  = SRC_A_FACT;
                cmd.src_b  = SRC_B_FWD;
                cmd.wr_dst = DST_FWD;
            end
            default:
            begin
                cmd.src_a  = SRC_A_FACT;
                cmd.src_b  = SRC_B_BWD;
                cmd.wr_dst = DST_BWD;
            end
        endcase

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.in_we = 1'b1;
                    load_next = load_reg + AW'(1);
                    if (load_reg == AW'(N * N - 1))
                    begin
                        load_next  = '0;
                        phase_next = PH_GRAM;
                        i_next     = '0;
                        j_next     = '0;
                        col_next   = '0;
                        state_next = S_INIT_RD;
                    end
                end
            end
            S_INIT_RD:
            begin
                cmd.addr_a = idx(i_reg, j_reg);
                cmd.addr_b = AW'(i_reg);
                state_next = S_INIT_LD;
            end
            S_INIT_LD:
            begin
                cmd.init_load = 1'b1;
                case (phase_reg)
                    PH_GRAM: cmd.init_sel = (i_reg == j_reg) ? INIT_ETA : INIT_ZERO;
                    PH_FACT: cmd.init_sel = INIT_GRAM;
                    PH_FWD:  cmd.init_sel = (i_reg == col_reg) ? INIT_ONE : INIT_ZERO;
                    default: cmd.init_sel = INIT_FWD;
                endcase
                k_next     = '0;
                state_next = (nterms == '0) ? S_FIN_RD : S_OP_RD;
            end
            S_OP_RD:
            begin
                case (phase_reg)
                    PH_GRAM:
                    begin
                        cmd.addr_a = idx(i_reg, k_reg);
                        cmd.addr_b = idx(k_reg, j_reg);
                    end
                    PH_FACT:
                    begin
                        cmd.addr_a = idx(i_reg, k_reg);
                        cmd.addr_b = idx(j_reg, k_reg);
                    end
                    PH_FWD:
                    begin
                        cmd.addr_a = idx(i_reg, k_reg);
                        cmd.addr_b = AW'(k_reg);
                    end
                    default:
                    begin
                        cmd.addr_a = idx(p_bw, i_reg);
                        cmd.addr_b = AW'(p_bw);
                    end
                endcase
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.arith_start = 1'b1;
                cmd.arith_op    = OP_MUL;
                state_next      = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (sts.arith_done)
                begin
                    cmd.acc_update = 1'b1;
                    if (last_term)
                    begin
                        state_next = S_FIN_RD;
                    end
                    else
                    begin
                        k_next     = k_reg + IW'(1);
                        state_next = S_OP_RD;
                    end
                end
            end
            S_FIN_RD:
            begin
                cmd.addr_a = idx(i_reg, i_reg);
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (phase_reg == PH_GRAM)
                begin
                    state_next = S_WR;
                end
                else if (phase_reg == PH_FACT && i_reg == j_reg)
                begin
                    if (sts.acc_nonpos)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        cmd.arith_start = 1'b1;
                        cmd.arith_op    = OP_SQRT;
                        state_next      = S_FIN_WAIT;
                    end
                end
                else
                begin
                    cmd.arith_start = 1'b1;
                    cmd.arith_op    = OP_DIV;
                    state_next      = S_FIN_WAIT;
                end
            end
            S_FIN_WAIT:
            begin
                if (sts.arith_done)
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                cmd.wr_en  = 1'b1;
                state_next = S_INIT_RD;
                case (phase_reg)
                    PH_GRAM, PH_FACT:
                    begin
                        cmd.wr_addr = (phase_reg == PH_FACT) ? idx(j_reg, i_reg)
                                                             : idx(i_reg, j_reg);
                        if (j_reg != IMAX)
                        begin
                            j_next = j_reg + IW'(1);
                        end
                        else if (i_reg != IMAX)
                        begin
                            i_next = i_reg + IW'(1);
                            j_next = i_reg + IW'(1);
                        end
                        else
                        begin
                            i_next     = '0;
                            j_next     = '0;
                            phase_next = (phase_reg == PH_GRAM) ? PH_FACT : PH_FWD;
                        end
                    end
                    PH_FWD:
                    begin
                        cmd.wr_addr = AW'(i_reg);
                        if (i_reg != IMAX)
                        begin
                            i_next = i_reg + IW'(1);
                        end
                        else
                        begin
                            phase_next = PH_BWD;
                        end
                    end
                    default:
                    begin
                        cmd.wr_addr = AW'(i_reg);
                        if (i_reg != '0)
                        begin
                            i_next = i_reg - IW'(1);
                        end
                        else
                        begin
                            state_next = S_OUT_RD;
                        end
                    end
                endcase
            end
            S_OUT_RD:
            begin
                cmd.addr_b = AW'(i_reg);
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                cmd.addr_b = AW'(i_reg);
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (i_reg != IMAX)
                    begin
                        i_next     = i_reg + IW'(1);
                        state_next = S_OUT_RD;
                    end
                    else if (col_reg == IMAX)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        col_next   = col_reg + IW'(1);
                        i_next     = '0;
                        phase_next = PH_FWD;
                        state_next = S_INIT_RD;
                    end
                end
            end
            S_ERR:
            begin
                if (sts.out_free)
                begin
                    cmd.out_err = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_GRAM;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            col_reg   <= '0;
            load_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            col_reg   <= col_next;
            load_reg  <= load_next;
        end
    end

endmodule

[design/regularized_matrix_inverse_unit.sv]
// ----------------------------------------------------------------------------
// regularized_matrix_inverse_unit: inverse of C*C + eta*I by Cholesky
// Loads an 8x8 Q8.24 matrix, factors, solves and streams the inverse out.
//
//   channel  dir  handshake            payload
//   s_       in   s_tvalid/s_tready    tdata[31:0] value
//   m_       out  m_tvalid/m_tready    tdata value,row,col; tlast; tuser flags
//   cfg_     in   cfg_valid/cfg_ready  cfg_data[30:0] eta
//
// One element per cycle while loading; the 64th starts a solve.
// Multiplies, divides and roots share one arithmetic unit.
// Results leave in bursts of eight; m_tready low holds the output register and
// stalls the solve at the next result.
// rst_n clears control state and restores eta; stores hold no reset value.
// ----------------------------------------------------------------------------
module regularized_matrix_inverse_unit
    import rmi_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [31:0]   s_tdata,   // [31:0] value
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata,   // [31:0] value_res, [34:32] row, [37:35] col
    output logic          m_tlast,
    output logic [1:0]    m_tuser,   // [0] not_pos_def, [1] saturated
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [30:0]   cfg_data
);

    rmi_cmd_t cmd;
    rmi_sts_t sts;

    assign cfg_ready = 1'b1;

    rmi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rmi_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == 40'd0)
        else $error("error transfer without last or with data");

    a_busy_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.arith_start || sts.arith_done |-> !s_tready)
        else $error("arithmetic active while loading");

    a_out_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load || cmd.out_err |-> sts.out_free)
        else $error("output register overwritten");
`endif

endmodule

[sim/regularized_matrix_inverse_unit_tb.sv]
// ----------------------------------------------------------------------------
// regularized_matrix_inverse_unit_tb: self-checking bench for the inverse unit
// Streams 8x8 Q8.24 matrices with random gaps, predicts inv(C*C + eta*I) with
// a bit-exact Cholesky model, and checks each inverse element as it leaves.
// ----------------------------------------------------------------------------
module regularized_matrix_inverse_unit_tb;
    import rmi_pkg::*;

    typedef logic signed [63:0] q_t;

    typedef struct {
        logic [31:0] value;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        last;
        logic        npd;
        logic        sat;
    } inv_elem_t;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAT_NONE    = 0;
    localparam int MAT_IDENT   = 1;
    localparam int MAT_ZERO    = 2;
    localparam int MAT_TINY    = 3;
    localparam int MAT_EXTREME = 4;
    localparam int MAT_SYM     = 5;
    localparam int MAT_NOISE   = 6;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [30:0] cfg_data;

    logic [31:0] pending_elems[$];
    inv_elem_t   inverse_expect[$];
    logic [30:0] eta_model;
    q_t          c_mat[64];
    q_t          b_mat[64];
    q_t          l_mat[64];
    q_t          fwd_vec[8];
    q_t          bwd_vec[8];
    int          load_cnt;
    int          mismatches;
    int          cycles;
    bit          s_fired;
    bit          no_idle;
    bit          hold_arm;
    bit          hold_used;
    int          hold_left;

    regularized_matrix_inverse_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic q_t sat_q(input q_t v);
        if (v > LIM)
            return LIM;
        if (v < -LIM)
            return -LIM;
        return v;
    endfunction

    function automatic q_t q_mul(input q_t a, input q_t b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [63:0]  r;
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        p = {64'd0, ua} * {64'd0, ub};
        p = p + (128'd1 << 23);
        if (p[127:86] != 0)
            r = LIM_U;
        else
        begin
            r = p[87:24];
            if (r > LIM_U)
                r = LIM_U;
        end
        return ((a < 0) != (b < 0)) ? -q_t'(r) : q_t'(r);
    endfunction

    function automatic q_t q_div(input q_t num, input q_t den);
        logic [63:0]  mag;
        logic [127:0] quo;
        if (den <= 0)
            return 0;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        quo = ({64'd0, mag} << 24) / {64'd0, 64'(den)};
        if (quo > {64'd0, LIM_U})
            quo = {64'd0, LIM_U};
        return (num < 0) ? -q_t'(quo[63:0]) : q_t'(quo[63:0]);
    endfunction

    function automatic q_t q_root(input q_t x);
        logic [127:0] v;
        logic [63:0]  root;
        logic [63:0]  t;
        v = {64'd0, 64'(x)} << 24;
        root = 0;
        for (int b = 63; b >= 0; b--)
        begin
            t = root | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= v)
                root = t;
        end
        return q_t'(root);
    endfunction

    function automatic bit factor_gram();
        q_t s;
        for (int i = 0; i < N; i++)
            for (int j = i; j < N; j++)
            begin
                s = (i == j) ? q_t'({33'd0, eta_model}) : 0;
                for (int k = 0; k < N; k++)
                    s = sat_q(s + q_mul(c_mat[i*N+k], c_mat[k*N+j]));
                b_mat[i*N+j] = s;
                b_mat[j*N+i] = s;
            end
        for (int i = 0; i < N; i++)
            for (int j = i; j < N; j++)
            begin
                s = b_mat[i*N+j];
                for (int k = 0; k < i; k++)
                    s = sat_q(s - q_mul(l_mat[i*N+k], l_mat[j*N+k]));
                if (i == j)
                begin
                    if (s <= 0)
                        return 0;
                    l_mat[i*N+i] = q_root(s);
                end
                else
                    l_mat[j*N+i] = q_div(s, l_mat[i*N+i]);
            end
        return 1;
    endfunction

    task automatic absorb_element(input logic [31:0] v);
        inv_elem_t e;
        q_t        x;
        c_mat[load_cnt] = q_t'($signed(v));
        load_cnt++;
        if (load_cnt < N * N)
            return;
        load_cnt = 0;
        if (!factor_gram())
        begin
            e = '{value: 0, row: 0, col: 0, last: 1, npd: 1, sat: 0};
            inverse_expect.push_back(e);
            return;
        end
        for (int i = 0; i < N; i++)
        begin
            for (int r = 0; r < N; r++)
            begin
                x = (r == i) ? ONE_Q : 0;
                for (int p = 0; p < r; p++)
                    x = sat_q(x - q_mul(l_mat[r*N+p], fwd_vec[p]));
                fwd_vec[r] = q_div(x, l_mat[r*N+r]);
            end
            for (int r = N - 1; r >= 0; r--)
            begin
                x = fwd_vec[r];
                for (int p = N - 1; p > r; p--)
                    x = sat_q(x - q_mul(l_mat[p*N+r], bwd_vec[p]));
                bwd_vec[r] = q_div(x, l_mat[r*N+r]);
            end
            for (int r = 0; r < N; r++)
            begin
                x = bwd_vec[r];
                e.sat = 0;
                if (x > 64'sh7FFF_FFFF)
                begin
                    x = 64'sh7FFF_FFFF;
                    e.sat = 1;
                end
                if (x < -64'sh8000_0000)
                begin
                    x = -64'sh8000_0000;
                    e.sat = 1;
                end
                e.value = x[31:0];
                e.row = 3'(i);
                e.col = 3'(r);
                e.last = (i == N - 1 && r == N - 1);
                e.npd = 0;
                inverse_expect.push_back(e);
            end
        end
    endtask

    function automatic logic [31:0] pick_elem(input int kind, input int r, input int c);
        case (kind)
            MAT_IDENT:   return (r == c) ? 32'h0100_0000 : 32'h0;
            MAT_ZERO:    return 32'h0;
            MAT_TINY:    return (r == c) ? 32'h0000_1000 : 32'h0;
            MAT_EXTREME:
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    default: return $urandom;
                endcase
            MAT_SYM:
                return (r == c) ? 32'($urandom_range(32'h0080_0000, 32'h0400_0000))
                                : 32'(int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000);
            default:     return $urandom;
        endcase
    endfunction

    task automatic queue_matrix(input int kind);
        logic [31:0] m[64];
        for (int r = 0; r < N; r++)
            for (int c = 0; c < N; c++)
                if (kind == MAT_SYM && c < r)
                    m[r*N+c] = m[c*N+r];
                else
                    m[r*N+c] = pick_elem(kind, r, c);
        for (int i = 0; i < N * N; i++)
            pending_elems.push_back(m[i]);
    endtask

    task automatic drain_results();
        wait (pending_elems.size() == 0 && !s_tvalid && inverse_expect.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_eta(input logic [30:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        s_fired <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
            absorb_element(s_tdata);
        if (cfg_valid && cfg_ready)
            eta_model <= cfg_data;
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_fired))
        begin
            if (pending_elems.size() > 0 && (no_idle || $urandom_range(0, 99) >= 15))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_elems.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_arm && !hold_used && m_tvalid)
            begin
                hold_used <= 1'b1;
                hold_left <= 3000;
                m_tready  <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= no_idle || $urandom_range(0, 99) >= 15;
        end
    end

    always @(posedge clk)
    begin
        inv_elem_t e;
        if (m_tvalid && m_tready)
        begin
            if (inverse_expect.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: tdata=%h tlast=%b tuser=%b",
                             m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                e = inverse_expect.pop_front();
                if (m_tdata[31:0] !== e.value || m_tdata[34:32] !== e.row
                    || m_tdata[37:35] !== e.col || m_tlast !== e.last
                    || m_tuser[0] !== e.npd || m_tuser[1] !== e.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp val=%h r=%0d c=%0d last=%b npd=%b sat=%b",
                                 e.value, e.row, e.col, e.last, e.npd, e.sat,
                                 " got val=%h r=%0d c=%0d last=%b npd=%b sat=%b",
                                 m_tdata[31:0], m_tdata[34:32], m_tdata[37:35],
                                 m_tlast, m_tuser[0], m_tuser[1]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        eta_model = ETA_RESET;
        load_cnt  = 0;
        mismatches = 0;
        cycles    = 0;
        s_fired   = 1'b0;
        no_idle   = 1'b0;
        hold_arm  = 1'b0;
        hold_used = 1'b0;
        hold_left = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_matrix(MAT_TINY);
        drain_results();
        write_eta(31'd0);
        queue_matrix(MAT_ZERO);
        drain_results();

        write_eta(31'($urandom_range(0, 32'h0100_0000)));
        hold_arm = 1'b1;
        queue_matrix(MAT_SYM);
        queue_matrix(MAT_EXTREME);
        drain_results();

        no_idle = 1'b1;
        write_eta(31'($urandom));
        queue_matrix(MAT_NOISE);
        drain_results();
        no_idle = 1'b0;

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
